// File: src/mi_pkg.sv
// Shared constants and types for the modular inverse unit.
`default_nettype none

package mi_pkg;

    // Default operand width in bits.
    localparam int unsigned WIDTH_DEF = 31;

    // Sequencer states, one-hot coded.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// File: src/mi_step.sv
// Shared datapath step: one restoring-division bit fused with a Horner multiply-accumulate bit.
`default_nettype none

module mi_step #(
    parameter int unsigned WIDTH = mi_pkg::WIDTH_DEF
) (
    input  wire logic [WIDTH-1:0] i_rem,
    input  wire logic [WIDTH-1:0] i_dq,
    input  wire logic [WIDTH-1:0] i_divisor,
    input  wire logic [WIDTH-1:0] i_acc,
    input  wire logic [WIDTH-1:0] i_prev,
    output logic      [WIDTH-1:0] o_rem,
    output logic      [WIDTH-1:0] o_dq,
    output logic      [WIDTH-1:0] o_acc
);

    logic [WIDTH:0] shifted;
    logic [WIDTH:0] diff;
    logic           qbit;

    // Bring down the next dividend bit and try the subtraction.
    assign shifted = {i_rem, i_dq[WIDTH-1]};
    assign diff    = shifted - {1'b0, i_divisor};
    assign qbit    = (shifted >= {1'b0, i_divisor});

    // The partial remainder stays below the divisor, so it fits in WIDTH bits.
    assign o_rem = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    assign o_dq  = {i_dq[WIDTH-2:0], qbit};

    // Quotient bits arrive MSB first, so the product builds up by doubling.
    assign o_acc = {i_acc[WIDTH-2:0], 1'b0} + (qbit ? i_prev : '0);

endmodule

`default_nettype wire

// File: src/modular_inverse_unit.sv
// Top level of the modular inverse unit: sequencer, operand registers and result register.
//
// Channel   Direction  Handshake            Payload
// command   in         start, busy          i_value, i_modulus
// result    out        o_valid (strobe)     o_inverse, o_no_inverse
//
// Each Euclid round passes through the check state, the shared division step
// (one quotient bit per cycle, for every bit of the dividend, with the coefficient
// update folded in) and the swap of the pair. Special cases finish after
// the first check. For 31-bit operands this is at most about 45 rounds. Reset
// is synchronous and returns the sequencer to idle. The result strobe lasts one
// cycle and the receiver cannot stall it; busy is low again in the strobe cycle.
`default_nettype none

module modular_inverse_unit #(
    parameter int unsigned WIDTH = mi_pkg::WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [WIDTH-1:0] i_value,
    input  wire logic [WIDTH-1:0] i_modulus,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_inverse,
    output logic                  o_no_inverse
);

    localparam int unsigned CW = $clog2(WIDTH);

    mi_pkg::t_state r_state, n_state;

    logic [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0] r_m, n_m;
    logic [WIDTH-1:0] r_m0, n_m0;
    logic [WIDTH-1:0] r_cur, n_cur;
    logic [WIDTH-1:0] r_prev, n_prev;
    logic             r_neg, n_neg;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_dq, n_dq;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic [WIDTH-1:0] r_inv, n_inv;
    logic             r_noinv, n_noinv;

    logic [WIDTH-1:0] step_rem;
    logic [WIDTH-1:0] step_dq;
    logic [WIDTH-1:0] step_acc;

    // Shared division and multiply-accumulate step.
    mi_step #(
        .WIDTH(WIDTH)
    ) u_step (
        .i_rem    (r_rem),
        .i_dq     (r_dq),
        .i_divisor(r_m),
        .i_acc    (r_acc),
        .i_prev   (r_prev),
        .o_rem    (step_rem),
        .o_dq     (step_dq),
        .o_acc    (step_acc)
    );

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_m     = r_m;
        n_m0    = r_m0;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_dq    = r_dq;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_inv   = r_inv;
        n_noinv = r_noinv;
        case (r_state)
            mi_pkg::S_IDLE: begin
                if (start) begin
                    n_a     = i_value;
                    n_m     = i_modulus;
                    n_m0    = i_modulus;
                    n_cur   = WIDTH'(1);
                    n_prev  = '0;
                    n_neg   = 1'b0;
                    n_state = mi_pkg::S_CHECK;
                end
            end
            mi_pkg::S_CHECK: begin
                if (r_m0 == WIDTH'(1)) begin
                    // A modulus of one gives zero.
                    n_inv   = '0;
                    n_noinv = 1'b0;
                    n_valid = 1'b1;
                    n_state = mi_pkg::S_IDLE;
                end else if (r_a <= WIDTH'(1)) begin
                    // Pair reduced to one: fold a negative coefficient into range.
                    n_inv   = (r_neg && (r_cur != '0)) ? (r_m0 - r_cur) : r_cur;
                    n_noinv = 1'b0;
                    n_valid = 1'b1;
                    n_state = mi_pkg::S_IDLE;
                end else if (r_m == '0) begin
                    // Zero divisor: the operands share a factor or the modulus is zero.
                    n_inv   = '0;
                    n_noinv = 1'b1;
                    n_valid = 1'b1;
                    n_state = mi_pkg::S_IDLE;
                end else begin
                    n_rem   = '0;
                    n_dq    = r_a;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = mi_pkg::S_DIV;
                end
            end
            mi_pkg::S_DIV: begin
                n_rem = step_rem;
                n_dq  = step_dq;
                n_acc = step_acc;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(WIDTH - 1)) begin
                    n_state = mi_pkg::S_FIN;
                end
            end
            mi_pkg::S_FIN: begin
                // Keep (divisor, remainder) and advance the coefficients.
                n_a     = r_m;
                n_m     = r_rem;
                n_prev  = r_acc + r_cur;
                n_cur   = r_prev;
                n_neg   = ~r_neg;
                n_state = mi_pkg::S_CHECK;
            end
            default: begin
                n_state = mi_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mi_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_m     <= n_m;
        r_m0    <= n_m0;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_neg   <= n_neg;
        r_rem   <= n_rem;
        r_dq    <= n_dq;
        r_acc   <= n_acc;
        r_cnt   <= n_cnt;
        r_inv   <= n_inv;
        r_noinv <= n_noinv;
    end

    assign busy         = (r_state != mi_pkg::S_IDLE);
    assign o_valid      = r_valid;
    assign o_inverse    = r_inv;
    assign o_no_inverse = r_noinv;

`ifndef SYNTHESIS
    // A result is only shown once the sequencer is back in idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // A missing inverse always reads as zero.
    a_noinv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_inverse) |-> (o_inverse == '0))
        else $error("no-inverse result with nonzero value");

    // An accepted command makes the unit busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not start the sequencer");

    // The result strobe is a single-cycle pulse.
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // The division step count stays within the operand width.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mi_pkg::S_DIV) |-> (r_cnt <= CW'(WIDTH - 1)))
        else $error("division step counter out of range");
`endif

endmodule

`default_nettype wire

// File: test/modular_inverse_unit_tb.sv
// Self-checking testbench for the modular inverse unit: directed edge cases and random pairs.

module modular_inverse_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned W           = mi_pkg::WIDTH_DEF;
    localparam int unsigned RANDOM_CMDS = 400;
    // Run-time cap for the slowest legal run of all 422 commands.
    localparam int unsigned CYCLE_LIMIT = 2_600_000;
    // Longest command latency plus margin, waited out after the last result.
    localparam int unsigned TAIL_CYCLES = 2000;

    localparam logic [W-1:0] MAX_OPERAND = '1;

    // One command as the sender presents it.
    typedef struct {
        logic [W-1:0] value;
        logic [W-1:0] modulus;
        int unsigned  gap;
        bit           drain_first;
    } t_inv_cmd;

    // One result as the block should report it.
    typedef struct {
        logic [W-1:0] inverse;
        logic         no_inverse;
    } t_inv_res;

    // Shapes of random operand pairs.
    typedef enum int unsigned {
        SHAPE_FULL,
        SHAPE_SMALL_MOD,
        SHAPE_TINY,
        SHAPE_SHARED,
        SHAPE_EDGE
    } t_pair_shape;

    logic         i_clk        = 1'b0;
    logic         i_rst_n      = 1'b0;
    logic         start        = 1'b0;
    logic [W-1:0] i_value      = '0;
    logic [W-1:0] i_modulus    = '0;
    logic         busy;
    logic         o_valid;
    logic [W-1:0] o_inverse;
    logic         o_no_inverse;

    t_inv_cmd    pending_cmds[$];
    t_inv_res    expected_results[$];
    bit          cmd_holding  = 1'b0;
    bit          cmd_accepted = 1'b0;
    int unsigned gap_count    = 0;
    int unsigned cycle_count  = 0;
    int unsigned error_count  = 0;
    int unsigned results_seen = 0;
    int unsigned no_inv_seen  = 0;
    int unsigned directed_cmds = 0;

    modular_inverse_unit #(
        .WIDTH(W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_modulus   (i_modulus),
        .o_valid     (o_valid),
        .o_inverse   (o_inverse),
        .o_no_inverse(o_no_inverse)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Extended Euclid with coefficient magnitudes and an alternating sign.
    function automatic t_inv_res predict_inverse(logic [W-1:0] value, logic [W-1:0] modulus);
        logic [63:0] a;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] cur_mag;
        logic [63:0] prev_mag;
        logic [63:0] next_mag;
        logic [63:0] corrected;
        bit          cur_neg;
        t_inv_res    res;
        a            = 64'(value);
        m            = 64'(modulus);
        cur_mag      = 64'd1;
        prev_mag     = 64'd0;
        cur_neg      = 1'b0;
        res.inverse    = '0;
        res.no_inverse = 1'b0;
        if (modulus == 1) begin
            return res;
        end
        while (a > 1) begin
            // A zero divisor means the pair shares a factor, or the modulus is zero.
            if (m == 0) begin
                res.no_inverse = 1'b1;
                return res;
            end
            q        = a / m;
            r        = a % m;
            a        = m;
            m        = r;
            next_mag = cur_mag + q * prev_mag;
            cur_mag  = prev_mag;
            prev_mag = next_mag;
            cur_neg  = !cur_neg;
        end
        if (cur_neg && cur_mag != 0) begin
            corrected = 64'(modulus) - cur_mag;
        end else begin
            corrected = cur_mag;
        end
        res.inverse = corrected[W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    task automatic queue_pair(logic [W-1:0] value, logic [W-1:0] modulus, bit drain_first,
                              bit no_gap);
        t_inv_cmd cmd;
        cmd.value       = value;
        cmd.modulus     = modulus;
        cmd.gap         = no_gap ? 0 : $urandom_range(0, 9);
        cmd.drain_first = drain_first;
        pending_cmds.push_back(cmd);
    endtask

    // Driver: presents queued commands at the falling edge, honoring each command's gap.
    always @(negedge i_clk) begin
        t_inv_cmd head;
        bit       drive_start;
        drive_start = 1'b0;
        if (cmd_holding && cmd_accepted) begin
            cmd_holding = 1'b0;
        end
        if (cmd_holding) begin
            drive_start = 1'b1;
        end else if (i_rst_n && pending_cmds.size() != 0) begin
            head = pending_cmds[0];
            if (head.drain_first && expected_results.size() != 0) begin
                // Hold off until every outstanding result has come back.
                drive_start = 1'b0;
            end else if (gap_count < head.gap) begin
                gap_count++;
            end else begin
                void'(pending_cmds.pop_front());
                gap_count   = 0;
                cmd_holding = 1'b1;
                drive_start = 1'b1;
                i_value   <= head.value;
                i_modulus <= head.modulus;
            end
        end
        start <= drive_start;
    end

    // Monitor: checks each result strobe, then records the expectation of a new transfer.
    always @(posedge i_clk) begin
        t_inv_res want;
        cycle_count  <= cycle_count + 1;
        cmd_accepted <= i_rst_n && start && (busy === 1'b0);
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result inverse=%0d no_inverse=%b with none pending",
                                              o_inverse, o_no_inverse));
                end else begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (want.no_inverse) begin
                        no_inv_seen++;
                    end
                    if (o_inverse !== want.inverse) begin
                        report_mismatch($sformatf("inverse %0d, expected %0d",
                                                  o_inverse, want.inverse));
                    end
                    if (o_no_inverse !== want.no_inverse) begin
                        report_mismatch($sformatf("no_inverse %b, expected %b",
                                                  o_no_inverse, want.no_inverse));
                    end
                end
            end
            if (start && busy === 1'b0) begin
                expected_results.push_back(predict_inverse(i_value, i_modulus));
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        t_pair_shape  shape;
        int unsigned  roll;
        int unsigned  factor;
        logic [W-1:0] value;
        logic [W-1:0] modulus;

        // Directed: special cases, extremes and the longest Euclid chain.
        queue_pair(0, 0, 1'b0, 1'b0);
        queue_pair(1, 0, 1'b0, 1'b0);
        queue_pair(0, 1, 1'b0, 1'b0);
        queue_pair(1, 1, 1'b0, 1'b0);
        queue_pair(MAX_OPERAND, 1, 1'b0, 1'b0);
        queue_pair(5, 0, 1'b0, 1'b0);
        queue_pair(MAX_OPERAND, 0, 1'b0, 1'b0);
        queue_pair(MAX_OPERAND, MAX_OPERAND, 1'b0, 1'b0);
        queue_pair(6, 9, 1'b0, 1'b0);
        queue_pair(2, 4, 1'b0, 1'b0);
        queue_pair(3, 7, 1'b0, 1'b0);
        queue_pair(10, 7, 1'b0, 1'b0);
        queue_pair(MAX_OPERAND, W'(MAX_OPERAND - 1), 1'b0, 1'b0);
        queue_pair(W'(MAX_OPERAND - 1), MAX_OPERAND, 1'b0, 1'b0);
        queue_pair(2, MAX_OPERAND, 1'b0, 1'b0);
        queue_pair(0, MAX_OPERAND, 1'b0, 1'b0);
        queue_pair(1, MAX_OPERAND, 1'b0, 1'b0);
        queue_pair(MAX_OPERAND, 2, 1'b0, 1'b0);
        queue_pair(31'h4000_0000, MAX_OPERAND, 1'b0, 1'b0);
        queue_pair(31'd1134903170, 31'd1836311903, 1'b0, 1'b0);
        queue_pair(31'd1836311903, 31'd1134903170, 1'b0, 1'b0);
        queue_pair(31'h5555_5555, 31'h2AAA_AAAA, 1'b0, 1'b0);
        directed_cmds = pending_cmds.size();

        // Random pairs, mostly full width, with shared factors and edge values mixed in.
        for (int unsigned k = 0; k < RANDOM_CMDS; k++) begin
            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                shape = SHAPE_FULL;
            end else if (roll == 5) begin
                shape = SHAPE_SMALL_MOD;
            end else if (roll == 6) begin
                shape = SHAPE_TINY;
            end else if (roll < 9) begin
                shape = SHAPE_SHARED;
            end else begin
                shape = SHAPE_EDGE;
            end
            value   = W'($urandom);
            modulus = W'($urandom);
            case (shape)
                SHAPE_SMALL_MOD: begin
                    modulus = W'($urandom_range(0, 31));
                end
                SHAPE_TINY: begin
                    value   = W'($urandom_range(0, 255));
                    modulus = W'($urandom_range(0, 255));
                end
                SHAPE_SHARED: begin
                    factor  = $urandom_range(2, 1000);
                    value   = W'(factor * $urandom_range(1, 2_000_000));
                    modulus = W'(factor * $urandom_range(1, 2_000_000));
                end
                SHAPE_EDGE: begin
                    case ($urandom_range(0, 3))
                        0: value = 0;
                        1: value = 1;
                        2: value = MAX_OPERAND;
                        default: ;
                    endcase
                    case ($urandom_range(0, 4))
                        0: modulus = 0;
                        1: modulus = 1;
                        2: modulus = 2;
                        3: modulus = MAX_OPERAND;
                        default: ;
                    endcase
                end
                default: ;
            endcase
            // Drain the block now and then; run a stretch back to back.
            queue_pair(value, modulus, (k % 97) == 0, k >= 200 && k < 240);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((pending_cmds.size() != 0 || cmd_holding || expected_results.size() != 0)
               && cycle_count < CYCLE_LIMIT) begin
            @(negedge i_clk);
        end
        if (cycle_count < CYCLE_LIMIT) begin
            repeat (TAIL_CYCLES) @(negedge i_clk);
        end

        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("modular_inverse_unit_tb failed");
        end else begin
            $display("Checked %0d results (%0d without an inverse) from %0d directed and",
                     results_seen, no_inv_seen, directed_cmds);
            $display("%0d random operand pairs in %0d cycles, %0d mismatches",
                     RANDOM_CMDS, cycle_count, error_count);
            if (error_count == 0) begin
                $display("modular_inverse_unit_tb passed");
            end else begin
                $display("modular_inverse_unit_tb failed");
            end
        end
        $finish;
    end

endmodule
